FILE: rtl/dct_pkg.sv
package dct_pkg;

    localparam int BLOCK_SIZE_DEF   = 8;
    localparam int SAMPLE_WIDTH_DEF = 12;
    localparam int NPIX             = 64;
    localparam int ROW_W            = 20;
    localparam int COEF_W           = 15;
    localparam int IDX_W            = 6;
    localparam int BASIS_W          = 15;

    localparam logic signed [ROW_W-1:0] ROW_MAX = 20'sd524287;
    localparam logic signed [ROW_W-1:0] ROW_MIN = -20'sd524288;
    localparam logic signed [COEF_W-1:0] OUT_MAX = 15'sd16383;
    localparam logic signed [COEF_W-1:0] OUT_MIN = -15'sd16384;

    // Basis value for frequency u at position n, signed Q1.14.
    function automatic logic signed [BASIS_W-1:0] basis(input logic [2:0] u,
                                                       input logic [2:0] n);
        logic [4:0] k;
        logic [4:0] kk;
        logic signed [BASIS_W-1:0] hc;
        logic [3:0] sel;
        k   = 5'(u * ({n, 1'b1}));
        kk  = (k > 5'd16) ? 5'(6'd32 - {1'b0, k}) : k;
        sel = (kk > 5'd8) ? 4'(5'd16 - kk) : kk[3:0];
        case (sel)
            4'd0:    hc = 15'sd8192;
            4'd1:    hc = 15'sd8035;
            4'd2:    hc = 15'sd7568;
            4'd3:    hc = 15'sd6811;
            4'd4:    hc = 15'sd5793;
            4'd5:    hc = 15'sd4551;
            4'd6:    hc = 15'sd3135;
            4'd7:    hc = 15'sd1598;
            default: hc = 15'sd0;
        endcase
        if (u == 3'd0) begin
            basis = 15'sd5793;
        end else if (kk > 5'd8) begin
            basis = -hc;
        end else begin
            basis = hc;
        end
    endfunction

    typedef enum logic [3:0] {
        ST_LOAD = 4'b0001,
        ST_ROW  = 4'b0010,
        ST_COL  = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

    // Control handed from the sequencer to every cell.
    typedef struct packed {
        logic       clear;   // start a fresh sum with this step's product
        logic       acc_en;  // add this step's product
        logic       is_col;  // column pass uses the column rounding
        logic [2:0] k;       // input position of this step
    } t_cell_ctl;

endpackage

FILE: rtl/dct_2d_8x8.sv
// Fixed-point 8x8 orthonormal DCT-II. Samples are taken in row-major order;
// after the 64th, the block computes the row pass and the column pass with a
// chain of eight multiply-accumulate cells, one per frequency, each doing
// one product a cycle. A pass over one row or column consists of the
// operand reads, the read and multiply pipeline, the load of the cells and
// the shift of the eight results down the chain into the result store. Each
// coefficient needs a registered store read before its output transfer.
// The time is set by the single product per cell per cycle, the serial
// shift-out of each line and the store read ahead of each output. Inputs
// are refused while a block is being transformed or emitted.
module dct_2d_8x8
    import dct_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [COEF_W-1:0]  o_coefficient,
    output logic [IDX_W-1:0]          o_coef_index,
    output logic                      o_block_last
);

    localparam int NB = BLOCK_SIZE_DEF;

    t_state r_state;
    logic [IDX_W-1:0] r_cnt;        // load count, and emit count
    logic [2:0]       r_line;       // row or column being transformed
    logic [4:0]       r_step;       // step within one line pass
    logic signed [ROW_W-1:0] r_smem [NPIX];
    logic signed [ROW_W-1:0] r_rmem [NPIX];
    logic signed [ROW_W-1:0] r_rd;
    logic signed [ROW_W-1:0] r_chain_rd;
    t_cell_ctl ctl;
    logic        load;
    logic signed [ROW_W-1:0] chain [NB+1];
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic        wr_en;
    logic        r_out_v;
    logic signed [COEF_W-1:0] r_out_c;
    logic [IDX_W-1:0] r_out_i;
    logic        r_emit_rd;     // read data for emit is valid
    logic [IDX_W-1:0] r_emit_idx;
    logic        can_issue;

    // Steps 0..7 read operands (memory read, operands and product are registered,
    // so products accumulate at steps 3..10); step 12 loads the cells; 13..20 shift out.
    assign ctl.k      = 3'(r_step - 5'd1);
    assign ctl.acc_en = (r_step >= 5'd1) && (r_step <= 5'd8);
    assign ctl.clear  = (r_step == 5'd1);
    assign ctl.is_col = (r_state == ST_COL);
    assign load       = (r_step == 5'd12);

    always_comb begin
        if (r_state == ST_ROW) begin
            rd_addr = {r_line, r_step[2:0]};
        end else if (r_state == ST_COL) begin
            rd_addr = {r_step[2:0], r_line};
        end else begin
            rd_addr = r_cnt;
        end
    end

    // Output position of the word leaving the chain end at steps 13..20.
    assign wr_en = (r_step >= 5'd13) && (r_step <= 5'd20)
                   && (r_state == ST_ROW || r_state == ST_COL);
    always_comb begin
        if (r_state == ST_ROW) begin
            wr_addr = {r_line, 3'(5'd20 - r_step)};
        end else begin
            wr_addr = {3'(5'd20 - r_step), r_line};
        end
    end

    assign chain[0] = '0;
    genvar g;
    generate
        for (g = 0; g < NB; g++) begin : g_cell
            dct_mac_cell u_cell (
                .i_clk       (i_clk),
                .i_freq      (3'(g)),
                .i_ctl       (ctl),
                .i_operand   (r_state == ST_COL ? r_chain_rd : r_rd),
                .i_load      (load),
                .i_shift_in  (chain[g]),
                .o_shift_out (chain[g+1])
            );
        end
    endgenerate

    assign o_ready   = (r_state == ST_LOAD);
    assign can_issue = !r_out_v || i_ready;

    always_ff @(posedge i_clk) begin
        if (r_state == ST_LOAD && i_valid) begin
            r_smem[r_cnt] <= ROW_W'(i_sample);
        end
        r_rd <= r_smem[rd_addr[IDX_W-1:0]];
        if (wr_en) begin
            r_rmem[wr_addr] <= chain[NB];
        end
        r_chain_rd <= r_rmem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_cnt     <= '0;
            r_line    <= '0;
            r_step    <= '0;
            r_out_v   <= 1'b0;
            r_emit_rd <= 1'b0;
        end else begin
            case (r_state)
                ST_LOAD: begin
                    if (i_valid) begin
                        r_cnt <= r_cnt + 1'b1;
                        if (r_cnt == IDX_W'(NPIX - 1)) begin
                            r_state <= ST_ROW;
                            r_line  <= '0;
                            r_step  <= '0;
                        end
                    end
                end
                ST_ROW, ST_COL: begin
                    if (r_step == 5'd20) begin
                        r_step <= '0;
                        r_line <= r_line + 1'b1;
                        if (r_line == 3'd7) begin
                            if (r_state == ST_ROW) begin
                                r_state <= ST_COL;
                            end else begin
                                r_state   <= ST_EMIT;
                                r_cnt     <= '0;
                                r_emit_rd <= 1'b0;
                            end
                        end
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                ST_EMIT: begin
                    // r_cnt addresses the store; r_chain_rd is valid in the
                    // cycle after an address is held.
                    if (r_out_v && i_ready && r_out_i == IDX_W'(NPIX - 1)) begin
                        r_out_v <= 1'b0;
                        r_state <= ST_LOAD;
                        r_cnt   <= '0;
                    end else begin
                        if (!r_emit_rd) begin
                            r_emit_rd  <= 1'b1;
                            r_emit_idx <= r_cnt;
                            if (r_out_v && i_ready) begin
                                r_out_v <= 1'b0;
                            end
                        end else if (can_issue && !(r_out_v && r_out_i == IDX_W'(NPIX-1))) begin
                            r_out_v   <= 1'b1;
                            r_out_c   <= r_chain_rd[COEF_W-1:0];
                            r_out_i   <= r_emit_idx;
                            r_cnt     <= r_emit_idx + 1'b1;
                            r_emit_rd <= (r_emit_idx == IDX_W'(NPIX - 1));
                        end else if (r_out_v && i_ready) begin
                            r_out_v <= 1'b0;
                        end
                    end
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end

    assign o_valid       = r_out_v;
    assign o_coefficient = r_out_c;
    assign o_coef_index  = r_out_i;
    assign o_block_last  = (r_out_i == IDX_W'(NPIX - 1));

endmodule

FILE: rtl/dct_mac_cell.sv
// One frequency lane: multiplies the broadcast operand by its basis value,
// accumulates eight products and rounds the sum. The finished value is
// shifted along the chain through r_shift toward the output end.
module dct_mac_cell
    import dct_pkg::*;
(
    input  logic                    i_clk,
    input  logic [2:0]              i_freq,
    input  t_cell_ctl               i_ctl,
    input  logic signed [ROW_W-1:0] i_operand,
    input  logic                    i_load,
    input  logic signed [ROW_W-1:0] i_shift_in,
    output logic signed [ROW_W-1:0] o_shift_out
);

    logic signed [BASIS_W-1:0]    r_coef;
    logic signed [ROW_W-1:0]      r_opnd;
    logic                         r_acc_en;
    logic                         r_clear;
    logic signed [35:0]           r_prod;
    logic                         r_p_en;
    logic                         r_p_clear;
    logic signed [38:0]           r_acc;
    logic signed [ROW_W-1:0]      r_shift;
    logic signed [38:0]           n_acc;
    logic signed [38:0]           rnd;
    logic signed [ROW_W-1:0]      sat;

    always_ff @(posedge i_clk) begin
        r_coef    <= basis(i_freq, i_ctl.k);
        r_opnd    <= i_operand;
        r_acc_en  <= i_ctl.acc_en;
        r_clear   <= i_ctl.clear;
        r_prod    <= 36'(r_coef * r_opnd);
        r_p_en    <= r_acc_en;
        r_p_clear <= r_clear;
        if (r_p_en) begin
            r_acc <= n_acc;
        end
        if (i_load) begin
            r_shift <= sat;
        end else begin
            r_shift <= i_shift_in;
        end
    end

    assign n_acc = (r_p_clear ? 39'sd0 : r_acc) + 39'(r_prod);

    // Row sums keep four fraction bits with ties up; column sums drop all
    // eighteen fraction bits with ties down.
    always_comb begin
        if (i_ctl.is_col) begin
            rnd = (r_acc + 39'sd131071) >>> 18;
            if (rnd > 39'(OUT_MAX)) begin
                sat = ROW_W'(OUT_MAX);
            end else if (rnd < 39'(OUT_MIN)) begin
                sat = ROW_W'(OUT_MIN);
            end else begin
                sat = rnd[ROW_W-1:0];
            end
        end else begin
            rnd = (r_acc + 39'sd512) >>> 10;
            if (rnd > 39'(ROW_MAX)) begin
                sat = ROW_MAX;
            end else if (rnd < 39'(ROW_MIN)) begin
                sat = ROW_MIN;
            end else begin
                sat = rnd[ROW_W-1:0];
            end
        end
    end

    assign o_shift_out = r_shift;

endmodule
